@@ design/tws_pkg.sv @@
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants for the timed wait sorted queue
// Queue depth, field widths, operation and status codes, cell commands.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_W       = 16;
  localparam int HANDLE_W    = 8;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_INF_KEY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_DRAIN  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_DRAIN = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_PREV = 2'd2,
    CELL_NEXT = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t           cmd;
    logic [KEY_W-1:0]    new_key;
    logic [HANDLE_W-1:0] new_handle;
  } cell_ctl_t;

  function automatic logic [QUEUE_DEPTH-1:0] prefix_or(input logic [QUEUE_DEPTH-1:0] v);
    logic [QUEUE_DEPTH-1:0] p;
    p = v;
    for (int s = 1; s < QUEUE_DEPTH; s = s * 2) begin
      p = p | (p << s);
    end
    return p;
  endfunction

endpackage

@@ design/tws_cell.sv @@
// ----------------------------------------------------------------------------
// tws_cell: one queue slot
// Holds a key and handle; loads a new entry or takes its neighbor's entry.
// ----------------------------------------------------------------------------
module tws_cell
  import tws_pkg::*;
(
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [KEY_W-1:0]    prev_key,
  input  logic [HANDLE_W-1:0] prev_handle,
  input  logic [KEY_W-1:0]    next_key,
  input  logic [HANDLE_W-1:0] next_handle,
  output logic [KEY_W-1:0]    key_r,
  output logic [HANDLE_W-1:0] handle_r
);

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CELL_LOAD: begin
        key_r    <= ctl.new_key;
        handle_r <= ctl.new_handle;
      end
      CELL_PREV: begin
        key_r    <= prev_key;
        handle_r <= prev_handle;
      end
      CELL_NEXT: begin
        key_r    <= next_key;
        handle_r <= next_handle;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/timed_wait_sorted_queue_top.sv @@
// ----------------------------------------------------------------------------
// timed_wait_sorted_queue_top: sorted insertion queue of task handles
// Result: registered, shown the cycle after start for append, insert and pop.
// Throughput: one such word per cycle while not busy; a drain of N entries emits
// N words, one per cycle from the front cell, holding busy while it runs.
// Reset: synchronous active low, empties the queue, resets state and config.
// ----------------------------------------------------------------------------
module timed_wait_sorted_queue_top
  import tws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_op,
  input  logic [HANDLE_W-1:0]  in_handle,
  input  logic [KEY_W-1:0]     in_wait_time,
  output logic                 out_valid,
  output logic [HANDLE_W-1:0]  out_handle,
  output logic [1:0]           out_status,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [KEY_W-1:0]    inf_key_r, max_wait_r;
  logic                ov_r, ov_nxt;
  logic [HANDLE_W-1:0] oh_r, oh_nxt;
  stat_t               os_r, os_nxt;
  logic                ol_r, ol_nxt;
  logic                do_ins, do_pop;
  logic [KEY_W-1:0]    new_key;
  logic [QUEUE_DEPTH-1:0] occ, match, pre;
  op_t                 op;

  logic [KEY_W-1:0]    key_q    [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] handle_q [QUEUE_DEPTH];
  cell_ctl_t           ctl      [QUEUE_DEPTH];

  assign op        = op_t'(in_op);
  assign busy      = (state_r == S_DRAIN);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inf_key_r  <= '0;
      max_wait_r <= '1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_INF_KEY) begin
        inf_key_r <= cfg_data;
      end else if (cfg_index == CFG_MAX_WAIT) begin
        max_wait_r <= cfg_data;
      end
    end
  end

  always_comb begin
    if (op != OP_INSERT) begin
      new_key = '0;
    end else if (in_wait_time == '0) begin
      new_key = inf_key_r;
    end else if (in_wait_time > max_wait_r) begin
      new_key = max_wait_r;
    end else begin
      new_key = in_wait_time;
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      occ[i]   = (CNT_W'(i) < count_r);
      match[i] = !occ[i] || ((op == OP_INSERT) && (key_q[i] >= new_key));
    end
  end

  assign pre = prefix_or(match);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ctl[i].new_key    = new_key;
      ctl[i].new_handle = in_handle;
      if (do_ins) begin
        if ((i > 0) && pre[(i > 0) ? i - 1 : 0]) begin
          ctl[i].cmd = CELL_PREV;
        end else if (match[i]) begin
          ctl[i].cmd = CELL_LOAD;
        end else begin
          ctl[i].cmd = CELL_HOLD;
        end
      end else if (do_pop) begin
        ctl[i].cmd = CELL_NEXT;
      end else begin
        ctl[i].cmd = CELL_HOLD;
      end
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    localparam int PI = (g > 0) ? g - 1 : 0;
    localparam int NI = (g < QUEUE_DEPTH - 1) ? g + 1 : g;
    tws_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[g]),
      .prev_key    (key_q[PI]),
      .prev_handle (handle_q[PI]),
      .next_key    (key_q[NI]),
      .next_handle (handle_q[NI]),
      .key_r       (key_q[g]),
      .handle_r    (handle_q[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ov_nxt    = 1'b0;
    oh_nxt    = '0;
    os_nxt    = STAT_OK;
    ol_nxt    = 1'b1;
    do_ins    = 1'b0;
    do_pop    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ov_nxt = 1'b1;
          case (op)
            OP_APPEND, OP_INSERT: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                os_nxt = STAT_FULL;
              end else begin
                do_ins    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                os_nxt = STAT_EMPTY;
              end else begin
                do_pop    = 1'b1;
                oh_nxt    = handle_q[0];
                count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_DRAIN: begin
              if (count_r == '0) begin
                os_nxt = STAT_EMPTY;
              end else begin
                do_pop    = 1'b1;
                oh_nxt    = handle_q[0];
                count_nxt = count_r - CNT_W'(1);
                ol_nxt    = (count_r == CNT_W'(1));
                if (count_r != CNT_W'(1)) begin
                  state_nxt = S_DRAIN;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DRAIN: begin
        ov_nxt    = 1'b1;
        do_pop    = 1'b1;
        oh_nxt    = handle_q[0];
        count_nxt = count_r - CNT_W'(1);
        ol_nxt    = (count_r == CNT_W'(1));
        if (count_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oh_r <= oh_nxt;
    os_r <= os_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid  = ov_r;
  assign out_handle = oh_r;
  assign out_status = os_r;
  assign out_last   = ol_r;

endmodule

@@ design/tws_checker.sv @@
// ----------------------------------------------------------------------------
// tws_checker: port level checks for the timed wait sorted queue
// Watches start, busy and the result strobe over time.
// ----------------------------------------------------------------------------
module tws_checker
  import tws_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic       out_last
);

  a_accept_word: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted command gave no result word");

  a_busy_word: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> out_valid)
    else $error("drain cycle without result word");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("non-final word while not draining");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> (out_last && !busy))
    else $error("error word not final");

endmodule

bind timed_wait_sorted_queue_top tws_checker u_tws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_last   (out_last)
);
